[rtl/spsv_pkg.sv]
// Shared types, widths and register defaults for the position servo core.
`timescale 1ns / 1ps

package spsv_pkg;

    localparam int POSITION_WIDTH_DEF     = 40;
    localparam int GAIN_FRACTION_BITS_DEF = 16;

    localparam int CMD_W       = 2;
    localparam int STEP_W      = 25;
    localparam int GAIN_W      = 16;
    localparam int MAX_STEP_W  = 24;
    localparam int BAND_W      = 24;
    localparam int LIMIT_W     = 16;
    localparam int COUNT_W     = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [GAIN_W-1:0]     GAIN_RESET     = 16'd3277;
    localparam logic [MAX_STEP_W-1:0] MAX_STEP_RESET = 24'd300000;
    localparam logic [BAND_W-1:0]     BAND_RESET     = 24'd1000;
    localparam logic [LIMIT_W-1:0]    LIMIT_RESET    = 16'd500;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_TICK  = 2'd2
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GAIN     = 2'd0,
        CFG_MAX_STEP = 2'd1,
        CFG_SETTLE   = 2'd2,
        CFG_LIMIT    = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic settled;
        logic limit_reached;
    } tick_flags_t;

endpackage

[rtl/spsv_tick_dp.sv]
// Combinational servo tick: saturated error, scaled and clamped step, new position.
`timescale 1ns / 1ps

module spsv_tick_dp #(
    parameter int POSITION_WIDTH     = spsv_pkg::POSITION_WIDTH_DEF,
    parameter int GAIN_FRACTION_BITS = spsv_pkg::GAIN_FRACTION_BITS_DEF
) (
    input  logic signed [POSITION_WIDTH-1:0]      target,
    input  logic signed [POSITION_WIDTH-1:0]      position,
    input  logic [spsv_pkg::COUNT_W-1:0]          tick_count,
    input  logic [spsv_pkg::GAIN_W-1:0]           gain,
    input  logic [spsv_pkg::MAX_STEP_W-1:0]       max_step,
    input  logic [spsv_pkg::BAND_W-1:0]           settle_band,
    input  logic [spsv_pkg::LIMIT_W-1:0]          cycle_limit,
    output logic signed [POSITION_WIDTH-1:0]      position_next,
    output logic signed [POSITION_WIDTH-1:0]      error,
    output logic signed [spsv_pkg::STEP_W-1:0]    step,
    output logic [spsv_pkg::COUNT_W-1:0]          tick_count_next,
    output spsv_pkg::tick_flags_t                 flags
);

    localparam int P    = POSITION_WIDTH;
    localparam int PW   = P + spsv_pkg::GAIN_W;
    localparam int RW   = PW + 1;

    localparam logic signed [P-1:0] POS_MAX = {1'b0, {(P-1){1'b1}}};
    localparam logic signed [P-1:0] POS_MIN = {1'b1, {(P-1){1'b0}}};
    localparam logic [RW-1:0]       HALF    = RW'(1) << (GAIN_FRACTION_BITS - 1);

    logic signed [P:0]                    diff;
    logic [P-1:0]                         mag;
    logic [PW-1:0]                        prod;
    logic [RW-1:0]                        rounded;
    logic [RW-1:0]                        scaled;
    logic [spsv_pkg::MAX_STEP_W-1:0]      step_mag;
    logic signed [P:0]                    sum;
    logic                                 settled;

    assign diff = (P+1)'(target) - (P+1)'(position);

    always_comb
    begin
        if (diff[P] != diff[P-1])
            error = diff[P] ? POS_MIN : POS_MAX;
        else
            error = diff[P-1:0];
    end

    assign mag     = error[P-1] ? (~error + P'(1)) : error;
    assign prod    = PW'(mag) * PW'(gain);
    assign rounded = RW'(prod) + HALF;
    assign scaled  = rounded >> GAIN_FRACTION_BITS;

    assign step_mag = (scaled > RW'(max_step)) ? max_step
                                               : scaled[spsv_pkg::MAX_STEP_W-1:0];
    assign step = error[P-1] ? -$signed({1'b0, step_mag}) : $signed({1'b0, step_mag});

    assign sum = (P+1)'(position) + (P+1)'(step);

    always_comb
    begin
        if (sum[P] != sum[P-1])
            position_next = sum[P] ? POS_MIN : POS_MAX;
        else
            position_next = sum[P-1:0];
    end

    assign settled         = mag < P'(settle_band);
    assign tick_count_next = (tick_count == {spsv_pkg::COUNT_W{1'b1}}) ? tick_count
                                                                     : tick_count + 1'b1;

    assign flags.settled       = settled;
    assign flags.limit_reached = !settled && (tick_count_next >= cycle_limit);

endmodule

[rtl/saturated_p_position_servo_core.sv]
// Top level of the saturated proportional position servo core.
//
// Usage:
//   Input beats on s_axis: tuser carries the command (load position, start a
//   segment toward a target, or one more tick), tdata the signed position or
//   target. Every input beat gives exactly one result beat on m_axis, carrying
//   position, error, step, settled, limit_reached and cycles_used.
//   Gains, step limit, settle band and cycle limit are written through the
//   cfg_we / cfg_index / cfg_wdata port while no beat is in flight; the user
//   must keep to this, as the block does not enforce it.
// Path: input register, then one tick evaluated into the result register.
// Throughput: one beat per cycle unless stalled. The position loop closes
//   through state registers and combinational multiply, clamp, saturating add.
// Reset: position, target and tick count clear, the segment reads as done,
//   the last tick result is zero and registers take their default values.
// Stall: with m_axis_tready low the result register holds; one more beat is
//   taken into the input register, after which s_axis_tready drops.
`timescale 1ns / 1ps

module saturated_p_position_servo_core #(
    parameter int POSITION_WIDTH     = spsv_pkg::POSITION_WIDTH_DEF,
    parameter int GAIN_FRACTION_BITS = spsv_pkg::GAIN_FRACTION_BITS_DEF,
    localparam int IN_W  = ((POSITION_WIDTH + 7) / 8) * 8,
    localparam int OUT_F = 2 * POSITION_WIDTH + spsv_pkg::STEP_W + 2 + spsv_pkg::COUNT_W,
    localparam int OUT_W = ((OUT_F + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [IN_W-1:0]                   s_axis_tdata,  // value
    input  logic [spsv_pkg::CMD_W-1:0]        s_axis_tuser,  // command
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // position, error, step, settled, limit_reached, cycles_used
    output logic [OUT_W-1:0]                  m_axis_tdata,
    input  logic                              cfg_we,
    input  logic [spsv_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [spsv_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int P = POSITION_WIDTH;

    logic [spsv_pkg::GAIN_W-1:0]      gain_reg;
    logic [spsv_pkg::MAX_STEP_W-1:0]  max_step_reg;
    logic [spsv_pkg::BAND_W-1:0]      band_reg;
    logic [spsv_pkg::LIMIT_W-1:0]     limit_reg;

    logic                             in_valid_reg;
    logic [spsv_pkg::CMD_W-1:0]       in_cmd_reg;
    logic signed [P-1:0]              in_value_reg;

    logic signed [P-1:0]              pos_reg;
    logic signed [P-1:0]              target_reg;
    logic [spsv_pkg::COUNT_W-1:0]     tick_reg;
    logic                             done_reg;
    logic signed [P-1:0]              last_error_reg;
    logic signed [spsv_pkg::STEP_W-1:0] last_step_reg;
    spsv_pkg::tick_flags_t            last_flags_reg;

    logic                             out_valid_reg;
    logic signed [P-1:0]              out_pos_reg;
    logic signed [P-1:0]              out_error_reg;
    logic signed [spsv_pkg::STEP_W-1:0] out_step_reg;
    spsv_pkg::tick_flags_t            out_flags_reg;
    logic [spsv_pkg::COUNT_W-1:0]     out_count_reg;

    logic                             advance;
    logic                             is_load;
    logic                             run;
    logic signed [P-1:0]              target_eff;
    logic [spsv_pkg::COUNT_W-1:0]     tick_eff;

    logic signed [P-1:0]              dp_position;
    logic signed [P-1:0]              dp_error;
    logic signed [spsv_pkg::STEP_W-1:0] dp_step;
    logic [spsv_pkg::COUNT_W-1:0]     dp_tick;
    spsv_pkg::tick_flags_t            dp_flags;

    logic signed [P-1:0]              pos_next;
    logic signed [P-1:0]              target_next;
    logic [spsv_pkg::COUNT_W-1:0]     tick_next;
    logic                             done_next;
    logic signed [P-1:0]              last_error_next;
    logic signed [spsv_pkg::STEP_W-1:0] last_step_next;
    spsv_pkg::tick_flags_t            last_flags_next;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // command decode; the unused code behaves as a tick
    always_comb
    begin
        unique case (in_cmd_reg)
            spsv_pkg::CMD_LOAD:
            begin
                is_load    = 1'b1;
                run        = 1'b0;
                target_eff = target_reg;
                tick_eff   = tick_reg;
            end
            spsv_pkg::CMD_START:
            begin
                is_load    = 1'b0;
                run        = 1'b1;
                target_eff = in_value_reg;
                tick_eff   = '0;
            end
            default:
            begin
                is_load    = 1'b0;
                run        = !done_reg;
                target_eff = target_reg;
                tick_eff   = tick_reg;
            end
        endcase
    end

    spsv_tick_dp #(
        .POSITION_WIDTH     (POSITION_WIDTH),
        .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
    ) u_tick_dp (
        .target          (target_eff),
        .position        (pos_reg),
        .tick_count      (tick_eff),
        .gain            (gain_reg),
        .max_step        (max_step_reg),
        .settle_band     (band_reg),
        .cycle_limit     (limit_reg),
        .position_next   (dp_position),
        .error           (dp_error),
        .step            (dp_step),
        .tick_count_next (dp_tick),
        .flags           (dp_flags)
    );

    always_comb
    begin
        pos_next        = pos_reg;
        target_next     = target_eff;
        tick_next       = tick_eff;
        done_next       = done_reg;
        last_error_next = last_error_reg;
        last_step_next  = last_step_reg;
        last_flags_next = last_flags_reg;
        if (is_load)
        begin
            pos_next = in_value_reg;
        end
        else if (run)
        begin
            pos_next        = dp_position;
            tick_next       = dp_tick;
            done_next       = dp_flags.settled || dp_flags.limit_reached;
            last_error_next = dp_error;
            last_step_next  = dp_step;
            last_flags_next = dp_flags;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg     <= spsv_pkg::GAIN_RESET;
            max_step_reg <= spsv_pkg::MAX_STEP_RESET;
            band_reg     <= spsv_pkg::BAND_RESET;
            limit_reg    <= spsv_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (spsv_pkg::cfg_idx_t'(cfg_index))
                spsv_pkg::CFG_GAIN:     gain_reg     <= cfg_wdata[spsv_pkg::GAIN_W-1:0];
                spsv_pkg::CFG_MAX_STEP: max_step_reg <= cfg_wdata[spsv_pkg::MAX_STEP_W-1:0];
                spsv_pkg::CFG_SETTLE:   band_reg     <= cfg_wdata[spsv_pkg::BAND_W-1:0];
                spsv_pkg::CFG_LIMIT:    limit_reg    <= cfg_wdata[spsv_pkg::LIMIT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            pos_reg        <= '0;
            target_reg     <= '0;
            tick_reg       <= '0;
            done_reg       <= 1'b1;
            last_error_reg <= '0;
            last_step_reg  <= '0;
            last_flags_reg <= '0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                pos_reg        <= pos_next;
                target_reg     <= target_next;
                tick_reg       <= tick_next;
                done_reg       <= done_next;
                last_error_reg <= last_error_next;
                last_step_reg  <= last_step_next;
                last_flags_reg <= last_flags_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_cmd_reg   <= s_axis_tuser;
            in_value_reg <= s_axis_tdata[P-1:0];
        end
        if (advance)
        begin
            out_pos_reg   <= pos_next;
            out_count_reg <= tick_next;
            if (is_load)
            begin
                out_error_reg <= '0;
                out_step_reg  <= '0;
                out_flags_reg <= '0;
            end
            else
            begin
                out_error_reg <= last_error_next;
                out_step_reg  <= last_step_next;
                out_flags_reg <= last_flags_next;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({out_count_reg, out_flags_reg.limit_reached,
                                   out_flags_reg.settled, out_step_reg,
                                   out_error_reg, out_pos_reg});

endmodule

[rtl/spsv_checker.sv]
// Port-level checks for the servo core, bound to the top level.
`timescale 1ns / 1ps

module spsv_checker #(
    parameter int POSITION_WIDTH = spsv_pkg::POSITION_WIDTH_DEF,
    parameter int OUT_W          = 128
) (
    input logic             clk,
    input logic             rst_n,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    localparam int STEP_LO    = 2 * POSITION_WIDTH;
    localparam int SETTLED_AT = STEP_LO + spsv_pkg::STEP_W;
    localparam int LIMIT_AT   = SETTLED_AT + 1;

    logic [spsv_pkg::STEP_W-1:0] step_field;
    assign step_field = m_axis_tdata[STEP_LO +: spsv_pkg::STEP_W];

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[SETTLED_AT] && m_axis_tdata[LIMIT_AT]))
        else $error("settled and limit_reached both set");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> step_field != {1'b1, {(spsv_pkg::STEP_W-1){1'b0}}})
        else $error("step outside clamp range");

endmodule

bind saturated_p_position_servo_core spsv_checker #(
    .POSITION_WIDTH (POSITION_WIDTH),
    .OUT_W          (OUT_W)
) u_spsv_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[tb/tb_saturated_p_position_servo_core.sv]
// Self-checking testbench for the saturated proportional position servo core.
`timescale 1ns / 1ps

module tb_saturated_p_position_servo_core;

    import spsv_pkg::*;

    localparam int POS_W       = POSITION_WIDTH_DEF;
    localparam int FRAC_BITS   = GAIN_FRACTION_BITS_DEF;
    localparam int IN_W        = ((POS_W + 7) / 8) * 8;
    localparam int OUT_F       = 2 * POS_W + STEP_W + 2 + COUNT_W;
    localparam int OUT_W       = ((OUT_F + 7) / 8) * 8;
    localparam int ERR_LO      = POS_W;
    localparam int STEP_LO     = 2 * POS_W;
    localparam int SETTLED_BIT = STEP_LO + STEP_W;
    localparam int LIMIT_BIT   = SETTLED_BIT + 1;
    localparam int CYCLES_LO   = LIMIT_BIT + 1;

    localparam longint POS_MAX = 64'sd549755813887;
    localparam longint POS_MIN = -64'sd549755813888;

    // unlisted command code, behaves as a tick
    localparam logic [CMD_W-1:0] CMD_TICK_ALT = 2'd3;

    localparam int HOLD_CYCLES = 150;
    localparam int STALL_LIMIT = 1000;

    typedef struct {
        logic signed [POS_W-1:0]  position;
        logic signed [POS_W-1:0]  error;
        logic signed [STEP_W-1:0] step;
        logic                     settled;
        logic                     limit_reached;
        logic [COUNT_W-1:0]       cycles_used;
    } servo_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_W-1:0]         s_axis_tdata;   // value
    logic [CMD_W-1:0]        s_axis_tuser;   // command
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    // position, error, step, settled, limit_reached, cycles_used
    logic [OUT_W-1:0]        m_axis_tdata;
    logic                    cfg_we;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_wdata;

    servo_result_t expected_results[$];
    int            failures     = 0;
    int            items_sent   = 0;
    int            stall_cycles = 0;
    bit            src_idle     = 1'b1;
    bit            sink_idle    = 1'b1;
    bit            hold_request = 1'b0;

    // servo state mirror
    longint             sv_position;
    longint             sv_target;
    int                 sv_ticks;
    bit                 sv_done;
    longint             sv_last_error;
    longint             sv_last_step;
    bit                 sv_last_settled;
    bit                 sv_last_limit;
    bit [GAIN_W-1:0]     reg_gain;
    bit [MAX_STEP_W-1:0] reg_max_step;
    bit [BAND_W-1:0]     reg_band;
    bit [LIMIT_W-1:0]    reg_limit;

    saturated_p_position_servo_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #2 clk = ~clk;

    function automatic longint clamp_pos(longint v);
        if (v > POS_MAX)
            return POS_MAX;
        if (v < POS_MIN)
            return POS_MIN;
        return v;
    endfunction

    // |err| * gain, rounded half away from zero, clamped to max step
    function automatic longint servo_step(longint err);
        bit [63:0] mag;
        bit [63:0] r;
        mag = (err < 0) ? -err : err;
        r = (mag * reg_gain + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (r > reg_max_step)
            r = reg_max_step;
        return (err < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic void servo_reset();
        sv_position     = 0;
        sv_target       = 0;
        sv_ticks        = 0;
        sv_done         = 1'b1;
        sv_last_error   = 0;
        sv_last_step    = 0;
        sv_last_settled = 1'b0;
        sv_last_limit   = 1'b0;
        reg_gain        = GAIN_RESET;
        reg_max_step    = MAX_STEP_RESET;
        reg_band        = BAND_RESET;
        reg_limit       = LIMIT_RESET;
    endfunction

    function automatic servo_result_t servo_predict(logic [CMD_W-1:0] cmd, longint val);
        servo_result_t res;
        longint        v;
        longint        err;
        bit [63:0]     mag;
        bit            settle;
        v = longint'($signed(val[POS_W-1:0]));
        if (cmd == CMD_LOAD)
        begin
            sv_position       = v;
            res.position      = sv_position[POS_W-1:0];
            res.error         = '0;
            res.step          = '0;
            res.settled       = 1'b0;
            res.limit_reached = 1'b0;
            res.cycles_used   = sv_ticks[COUNT_W-1:0];
            return res;
        end
        if (cmd == CMD_START)
        begin
            sv_target = v;
            sv_ticks  = 0;
            sv_done   = 1'b0;
        end
        if (!sv_done)
        begin
            err    = clamp_pos(sv_target - sv_position);
            mag    = (err < 0) ? -err : err;
            settle = mag < reg_band;
            sv_last_step = servo_step(err);
            sv_position  = clamp_pos(sv_position + sv_last_step);
            if (sv_ticks < 65535)
                sv_ticks++;
            sv_last_error   = err;
            sv_last_settled = settle;
            sv_last_limit   = !settle && (sv_ticks >= reg_limit);
            sv_done         = settle || sv_last_limit;
        end
        res.position      = sv_position[POS_W-1:0];
        res.error         = sv_last_error[POS_W-1:0];
        res.step          = sv_last_step[STEP_W-1:0];
        res.settled       = sv_last_settled;
        res.limit_reached = sv_last_limit;
        res.cycles_used   = sv_ticks[COUNT_W-1:0];
        return res;
    endfunction

    function automatic void compare_field(string name, longint want, longint got);
        if (want != got)
        begin
            failures++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    function automatic longint pick_position();
        bit [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return POS_MAX;
            1: return POS_MIN;
            2: return longint'($signed(r[20:0]));
            default: return longint'($signed(r[POS_W-1:0]));
        endcase
    endfunction

    // result checker
    always @(posedge clk)
    begin
        servo_result_t want;
        if (rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                failures++;
                $display("%0t: result beat with nothing expected, got %h", $time, m_axis_tdata);
            end
            else
            begin
                want = expected_results.pop_front();
                compare_field("position", want.position, $signed(m_axis_tdata[0 +: POS_W]));
                compare_field("error", want.error, $signed(m_axis_tdata[ERR_LO +: POS_W]));
                compare_field("step", want.step, $signed(m_axis_tdata[STEP_LO +: STEP_W]));
                compare_field("settled", want.settled, m_axis_tdata[SETTLED_BIT]);
                compare_field("limit_reached", want.limit_reached, m_axis_tdata[LIMIT_BIT]);
                compare_field("cycles_used", want.cycles_used,
                              m_axis_tdata[CYCLES_LO +: COUNT_W]);
            end
        end
    end

    // watchdog: cycles with work outstanding but no beat moving
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (expected_results.size() == 0 && !s_axis_tvalid))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: timeout, no beat moved for %0d cycles", $time, stall_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // result sink
    initial
    begin
        int pause;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                pause = sink_idle ? $urandom_range(0, 8) : 0;
                if (pause > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (pause) @(posedge clk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (m_axis_tvalid !== 1'b1);
        end
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd, input longint val);
        int            gap;
        servo_result_t res;
        gap = src_idle ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= val[POS_W-1:0];
        do @(posedge clk); while (s_axis_tready !== 1'b1);
        res = servo_predict(cmd, val);
        expected_results.insert(expected_results.size(), res);
        items_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // upper bits of narrow registers carry junk to check masking
    task automatic set_regs(input logic [GAIN_W-1:0] gain, input logic [MAX_STEP_W-1:0] max_step,
                            input logic [BAND_W-1:0] band, input logic [LIMIT_W-1:0] limit);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_GAIN;
        cfg_wdata <= {8'($urandom_range(0, 255)), gain};
        @(posedge clk);
        cfg_index <= CFG_MAX_STEP;
        cfg_wdata <= max_step;
        @(posedge clk);
        cfg_index <= CFG_SETTLE;
        cfg_wdata <= band;
        @(posedge clk);
        cfg_index <= CFG_LIMIT;
        cfg_wdata <= {8'($urandom_range(0, 255)), limit};
        @(posedge clk);
        cfg_we       <= 1'b0;
        reg_gain     = gain;
        reg_max_step = max_step;
        reg_band     = band;
        reg_limit    = limit;
    endtask

    task automatic test_reset_defaults();
        send_item(CMD_TICK, 0);
        send_item(CMD_TICK_ALT, POS_MAX);
        send_item(CMD_LOAD, POS_MAX);
        send_item(CMD_START, POS_MIN);
        send_item(CMD_TICK, 0);
        send_item(CMD_LOAD, POS_MIN);
        send_item(CMD_START, POS_MAX);
        send_item(CMD_TICK, 0);
        wait_idle();
    endtask

    task automatic test_settle_and_repeat();
        send_item(CMD_LOAD, 0);
        send_item(CMD_START, 500);
        send_item(CMD_TICK, 0);
        send_item(CMD_TICK_ALT, 0);
        send_item(CMD_LOAD, 1234);
        wait_idle();
    endtask

    task automatic test_register_extremes();
        // zero cycle limit: one tick ends the segment
        set_regs(16'hFFFF, 24'hFFFFFF, 24'd0, 16'd0);
        send_item(CMD_LOAD, 0);
        send_item(CMD_START, POS_MAX);
        send_item(CMD_TICK, 0);
        wait_idle();
        // rounding ties go away from zero
        set_regs(16'h8000, 24'hFFFFFF, 24'd0, 16'd1);
        send_item(CMD_LOAD, 0);
        send_item(CMD_START, 1);
        send_item(CMD_LOAD, 0);
        send_item(CMD_START, -1);
        wait_idle();
        // widest settle band, zero gain
        set_regs(16'd0, 24'd0, 24'hFFFFFF, 16'd3);
        send_item(CMD_START, 16777214);
        send_item(CMD_LOAD, 0);
        send_item(CMD_START, 16777215);
        send_item(CMD_TICK, 0);
        send_item(CMD_TICK, 0);
        send_item(CMD_TICK, 0);
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        set_regs(GAIN_RESET, MAX_STEP_RESET, BAND_RESET, LIMIT_RESET);
        src_idle     = 1'b0;
        hold_request = 1'b1;
        send_item(CMD_LOAD, 0);
        send_item(CMD_START, 10000000);
        for (int i = 0; i < 30; i++)
            send_item(CMD_TICK, 0);
        wait_idle();
        src_idle = 1'b1;
    endtask

    // widest cycle limit, never settles: the count keeps climbing
    task automatic test_long_segment();
        set_regs(16'd0, 24'd1000, 24'd0, 16'hFFFF);
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        send_item(CMD_LOAD, 0);
        send_item(CMD_START, 1000);
        for (int i = 0; i < 40; i++)
            send_item(CMD_TICK, 0);
        wait_idle();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    task automatic random_traffic(input int n_items);
        int     goal;
        int     ticks;
        longint offset;
        longint target;
        goal = items_sent + n_items;
        while (items_sent < goal)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                if ($urandom_range(0, 1))
                    send_item(CMD_LOAD, pick_position());
                offset = longint'($urandom_range(0, 2097152)) - 1048576;
                case ($urandom_range(0, 3))
                    0, 1: target = clamp_pos(sv_position + offset);
                    2:    target = pick_position();
                    default: target = clamp_pos(sv_position + offset * 16);
                endcase
                send_item(CMD_START, target);
                ticks = $urandom_range(0, 24);
                for (int i = 0; i < ticks; i++)
                begin
                    if ($urandom_range(0, 15) == 0)
                        send_item(CMD_LOAD, clamp_pos(sv_position + offset));
                    else
                        send_item(($urandom_range(0, 7) == 0) ? CMD_TICK_ALT : CMD_TICK,
                                  pick_position());
                end
            end
            else
            begin
                send_item(CMD_W'($urandom_range(0, 3)), pick_position());
            end
        end
    endtask

    task automatic test_random_settings();
        logic [GAIN_W-1:0]     gain;
        logic [MAX_STEP_W-1:0] max_step;
        logic [BAND_W-1:0]     band;
        logic [LIMIT_W-1:0]    limit;
        for (int phase = 0; phase < 5; phase++)
        begin
            case ($urandom_range(0, 5))
                0: gain = '0;
                1: gain = '1;
                2, 3: gain = GAIN_W'($urandom_range(1, 8192));
                default: gain = GAIN_W'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0: max_step = '0;
                1: max_step = '1;
                2: max_step = MAX_STEP_W'($urandom_range(1, 1000));
                default: max_step = MAX_STEP_W'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0: band = '0;
                1: band = '1;
                2, 3: band = BAND_W'($urandom_range(0, 50000));
                default: band = BAND_W'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0: limit = 16'd1;
                1: limit = '1;
                2: limit = 16'd0;
                default: limit = LIMIT_W'($urandom_range(2, 60));
            endcase
            set_regs(gain, max_step, band, limit);
            src_idle  = (phase % 3) != 2;
            sink_idle = (phase % 3) != 1;
            random_traffic(100);
            wait_idle();
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_LOAD;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_GAIN;
        cfg_wdata     <= '0;
        servo_reset();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_settle_and_repeat();
        test_register_extremes();
        test_output_backpressure();
        test_long_segment();
        test_random_settings();

        wait_idle();
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
